// ===== sv/edmf_pkg.sv =====
// ----------------------------------------------------------------------------
// edmf_pkg
// Shared widths, constants and the echo width to distance conversion.
// ----------------------------------------------------------------------------
package edmf_pkg;

  localparam int WIDTH_W     = 15;
  localparam int DIST_W      = 9;
  localparam int CNT_W       = 3;
  localparam int WIDTH_LIMIT = 30000;
  localparam int COUNT_MAX   = 7;

  // floor(w * 17 / 1000) == (w * RECIP_M) >> RECIP_SHIFT for every w <= 51150
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_M     = 285213;
  localparam int RECIP_W     = 19;
  localparam int PROD_W      = WIDTH_W + RECIP_W;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] dist_cm;
    logic [CNT_W-1:0]  cnt;
  } mode_res_t;

  function automatic logic [DIST_W-1:0] width_to_cm(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] v;
    logic [PROD_W-1:0]  p;
    v = (w > WIDTH_W'(WIDTH_LIMIT)) ? WIDTH_W'(WIDTH_LIMIT) : w;
    p = PROD_W'(v) * PROD_W'(RECIP_M);
    return p[RECIP_SHIFT +: DIST_W];
  endfunction

endpackage

// ===== sv/edmf_store.sv =====
// ----------------------------------------------------------------------------
// edmf_store
// Sample memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module edmf_store #(
  parameter int DEPTH = 5,
  parameter int AW    = 3
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [edmf_pkg::DIST_W-1:0] wr_data,
  input  logic [AW-1:0]              rd_addr,
  output logic [edmf_pkg::DIST_W-1:0] rd_data
);

  logic [edmf_pkg::DIST_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/edmf_mode.sv =====
// ----------------------------------------------------------------------------
// edmf_mode
// Mode sequencer: walks the batch pairwise through the sample memory and
// keeps the earliest value with the highest count.
// ----------------------------------------------------------------------------
module edmf_mode #(
  parameter int BATCH_SIZE = 5,
  parameter int AW         = 3,
  parameter int CW         = 3
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        go,
  output logic [AW-1:0]               rd_addr,
  input  logic [edmf_pkg::DIST_W-1:0] rd_data,
  output logic                        busy,
  output edmf_pkg::mode_res_t         res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CAPI,
    S_SCAN,
    S_EVAL
  } state_t;

  localparam logic [AW-1:0] LAST = AW'(BATCH_SIZE - 1);

  state_t                      state_r;
  logic [AW-1:0]               i_r;
  logic [AW-1:0]               j_r;
  logic [edmf_pkg::DIST_W-1:0] a_r;
  logic [CW-1:0]               cnt_r;
  logic [CW-1:0]               best_cnt_r;
  logic [edmf_pkg::DIST_W-1:0] best_val_r;
  edmf_pkg::mode_res_t         res_r;

  logic [CW-1:0]               win_cnt;
  logic [edmf_pkg::DIST_W-1:0] win_val;
  logic [edmf_pkg::CNT_W-1:0]  sat_cnt;

  // strictly greater keeps the earliest first occurrence on a tie
  always_comb begin
    if (cnt_r > best_cnt_r) begin
      win_cnt = cnt_r;
      win_val = a_r;
    end else begin
      win_cnt = best_cnt_r;
      win_val = best_val_r;
    end
    if (32'(win_cnt) > edmf_pkg::COUNT_MAX) begin
      sat_cnt = edmf_pkg::CNT_W'(edmf_pkg::COUNT_MAX);
    end else begin
      sat_cnt = edmf_pkg::CNT_W'(win_cnt);
    end
  end

  always_comb begin
    rd_addr = '0;
    unique case (state_r)
      S_IDLE: rd_addr = '0;
      S_CAPI: rd_addr = i_r + AW'(1);
      S_SCAN: rd_addr = j_r + AW'(1);
      S_EVAL: rd_addr = i_r + AW'(1);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_r.valid <= 1'b0;
    end else begin
      res_r.valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (go) begin
            i_r        <= '0;
            best_cnt_r <= '0;
            state_r    <= S_CAPI;
          end
        end
        S_CAPI: begin
          a_r   <= rd_data;
          cnt_r <= CW'(1);
          if (i_r == LAST) begin
            state_r <= S_EVAL;
          end else begin
            j_r     <= i_r + AW'(1);
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_data == a_r) begin
            cnt_r <= cnt_r + CW'(1);
          end
          if (j_r == LAST) begin
            state_r <= S_EVAL;
          end else begin
            j_r <= j_r + AW'(1);
          end
        end
        S_EVAL: begin
          best_cnt_r <= win_cnt;
          best_val_r <= win_val;
          if (i_r == LAST) begin
            res_r.valid   <= 1'b1;
            res_r.dist_cm <= win_val;
            res_r.cnt     <= sat_cnt;
            state_r       <= S_IDLE;
          end else begin
            i_r     <= i_r + AW'(1);
            state_r <= S_CAPI;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy = (state_r != S_IDLE);
  assign res  = res_r;

endmodule

// ===== sv/echo_distance_mode_filter.sv =====
// ----------------------------------------------------------------------------
// echo_distance_mode_filter
// Converts echo widths to distances, batches them and reports the batch mode.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: drive in_echo_width_us and raise start; the beat is taken at
//   the rising edge where start is high and busy is low. Widths above 30000
//   saturate; a zero width (timeout) counts as distance 0.
//   Each width becomes floor(width*17/1000) cm and is written to the sample
//   memory in the cycle after the beat is taken, so busy stays high for that
//   cycle. The beat that completes a batch of BATCH_SIZE samples starts the
//   mode sequencer, which reads the memory one entry per cycle through its
//   single read port: per sample i a load step, a compare against each later
//   sample and an update step. out_valid is high for one cycle at the end of
//   the pass, carrying the most frequent distance (earliest first occurrence
//   on a tie) and its count, held at 7. Busy drops in the same cycle as the
//   strobe.
//   The receiver cannot stall: a result beat is taken in its strobe cycle.
//   Reset (synchronous, rst_n low) empties the batch and idles the sequencer;
//   the sample memory is not cleared since every entry is written before read.
// ----------------------------------------------------------------------------
module echo_distance_mode_filter #(
  parameter int BATCH_SIZE = 5
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [edmf_pkg::WIDTH_W-1:0]  in_echo_width_us,
  output logic                          out_valid,
  output logic [edmf_pkg::DIST_W-1:0]   out_mode_distance_cm,
  output logic [edmf_pkg::CNT_W-1:0]    out_mode_count
);

  localparam int AW = (BATCH_SIZE > 1) ? $clog2(BATCH_SIZE) : 1;
  localparam int CW = $clog2(BATCH_SIZE + 1);
  localparam logic [AW-1:0] LAST = AW'(BATCH_SIZE - 1);

  logic                        accept;
  logic                        wr_pend_r;
  logic                        last_r;
  logic [edmf_pkg::DIST_W-1:0] dist_r;
  logic [AW-1:0]               idx_r;
  logic [AW-1:0]               idx_nxt;
  logic                        go;
  logic [AW-1:0]               rd_addr;
  logic [edmf_pkg::DIST_W-1:0] rd_data;
  logic                        mode_busy;
  edmf_pkg::mode_res_t         res;

  assign accept = start && !busy;
  assign busy   = wr_pend_r || mode_busy;

  // launch the mode scan together with the write of the batch's last sample
  assign go      = wr_pend_r && last_r;
  assign idx_nxt = (idx_r == LAST) ? '0 : idx_r + AW'(1);

  // capture the converted distance; write it back in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pend_r <= 1'b0;
      idx_r     <= '0;
    end else begin
      wr_pend_r <= accept;
      if (wr_pend_r) begin
        idx_r <= idx_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dist_r <= edmf_pkg::width_to_cm(in_echo_width_us);
      last_r <= (idx_r == LAST);
    end
  end

  edmf_store #(
    .DEPTH (BATCH_SIZE),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_pend_r),
    .wr_addr (idx_r),
    .wr_data (dist_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  edmf_mode #(
    .BATCH_SIZE (BATCH_SIZE),
    .AW         (AW),
    .CW         (CW)
  ) u_mode (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .busy    (mode_busy),
    .res     (res)
  );

  assign out_valid            = res.valid;
  assign out_mode_distance_cm = res.dist_cm;
  assign out_mode_count       = res.cnt;

  // a taken beat always holds off the next one for the write cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy low right after an accepted beat");

  // the sample index stays inside the batch
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= LAST)
    else $error("sample index out of range");

  // the last write of a batch always hands off to the sequencer
  a_go_scan: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> mode_busy && (idx_r == '0))
    else $error("batch end did not start the mode scan");

  // no new write may land while the sequencer reads the batch
  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    mode_busy |-> !wr_pend_r)
    else $error("sample write during mode scan");

  // results are single-cycle strobes
  a_strobe_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

// ===== tb/sv/echo_distance_mode_filter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echo_distance_mode_filter_tb
// Self-checking bench for the echo distance mode filter. A short table of
// echo widths covers saturation, timeouts, ties and a late mode. Random
// batches follow; most repeat a few widths so that real modes form. Every
// result beat is checked field by field against a batch predictor kept here.
// ----------------------------------------------------------------------------
module echo_distance_mode_filter_tb;

  localparam int WIDTH_W     = edmf_pkg::WIDTH_W;
  localparam int DIST_W      = edmf_pkg::DIST_W;
  localparam int CNT_W       = edmf_pkg::CNT_W;
  localparam int WIDTH_LIMIT = edmf_pkg::WIDTH_LIMIT;
  localparam int COUNT_MAX   = edmf_pkg::COUNT_MAX;

  localparam int N_BATCH     = 5;
  localparam int N_RANDOM    = 800;
  localparam int N_ROWS      = 25;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 40;    // well past the end of a sequencer pass

  // One directed row: a width and, on rows that close a batch, an optional
  // result typed in by hand.
  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic               typed;
    logic [DIST_W-1:0]  dist_cm;
    logic [CNT_W-1:0]   cnt;
  } echo_row_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_cm;
    logic [CNT_W-1:0]  cnt;
  } mode_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [WIDTH_W-1:0] in_echo_width_us = '0;
  logic               out_valid;
  logic [DIST_W-1:0]  out_mode_distance_cm;
  logic [CNT_W-1:0]   out_mode_count;

  // Predictor state: the distances of the open batch and how many are in.
  logic [DIST_W-1:0]  batch_dist [N_BATCH];
  int                 batch_fill;

  mode_beat_t         mode_q [$];
  int                 err_count;
  int                 cycle_count;

  // Directed table, five batches of five.
  echo_row_t dir_rows [N_ROWS] = '{
    // all widths at the limit: 510 cm five times
    '{15'd30000, 1'b0, 9'd0,   3'd0}, '{15'd30000, 1'b0, 9'd0,   3'd0},
    '{15'd30000, 1'b0, 9'd0,   3'd0}, '{15'd30000, 1'b0, 9'd0,   3'd0},
    '{15'd30000, 1'b1, 9'd510, 3'd5},
    // all timeouts: distance 0 counted like any other
    '{15'd0,     1'b0, 9'd0,   3'd0}, '{15'd0,     1'b0, 9'd0,   3'd0},
    '{15'd0,     1'b0, 9'd0,   3'd0}, '{15'd0,     1'b0, 9'd0,   3'd0},
    '{15'd0,     1'b1, 9'd0,   3'd5},
    // over-range widths saturate; tie between 510 and 0, 510 comes first
    '{15'd32767, 1'b0, 9'd0,   3'd0}, '{15'd30001, 1'b0, 9'd0,   3'd0},
    '{15'd1,     1'b0, 9'd0,   3'd0}, '{15'd58,    1'b0, 9'd0,   3'd0},
    '{15'd59,    1'b1, 9'd510, 3'd2},
    // mode that first shows up second: 3,7,7,7,3 gives 7 three times
    '{15'd177,   1'b0, 9'd0,   3'd0}, '{15'd412,   1'b0, 9'd0,   3'd0},
    '{15'd412,   1'b0, 9'd0,   3'd0}, '{15'd412,   1'b0, 9'd0,   3'd0},
    '{15'd177,   1'b1, 9'd7,   3'd3},
    // scattered bit patterns, all distinct; predictor only
    '{15'd16384, 1'b0, 9'd0,   3'd0}, '{15'd21845, 1'b0, 9'd0,   3'd0},
    '{15'd10922, 1'b0, 9'd0,   3'd0}, '{15'd1000,  1'b0, 9'd0,   3'd0},
    '{15'd29999, 1'b0, 9'd0,   3'd0}
  };

  echo_distance_mode_filter #(
    .BATCH_SIZE(N_BATCH)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_echo_width_us     (in_echo_width_us),
    .out_valid            (out_valid),
    .out_mode_distance_cm (out_mode_distance_cm),
    .out_mode_count       (out_mode_count)
  );

  always #5 clk = ~clk;

  // Hard stop: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Saturate, then scale: width * 0.034 / 2 in integer form.
  function automatic logic [DIST_W-1:0] echo_to_cm(input logic [WIDTH_W-1:0] w);
    int v;
    v = (int'(w) > WIDTH_LIMIT) ? WIDTH_LIMIT : int'(w);
    return DIST_W'((v * 17) / 1000);
  endfunction

  // Log one accepted width into the open batch. On the batch's last entry,
  // find the most frequent distance, earliest first occurrence on a tie.
  function automatic bit log_echo(input logic [WIDTH_W-1:0] w, output mode_beat_t res);
    int best_cnt;
    int hits;
    logic [DIST_W-1:0] best_val;
    if (batch_fill >= N_BATCH) batch_fill = 0;
    batch_dist[batch_fill] = echo_to_cm(w);
    batch_fill++;
    res = '0;
    if (batch_fill < N_BATCH) return 1'b0;
    batch_fill = 0;
    best_cnt = 0;
    best_val = batch_dist[0];
    for (int i = 0; i < N_BATCH; i++) begin
      hits = 1;
      for (int j = i + 1; j < N_BATCH; j++) begin
        if (batch_dist[i] == batch_dist[j]) hits++;
      end
      // strict greater-than keeps the earliest value on a tie
      if (hits > best_cnt) begin
        best_cnt = hits;
        best_val = batch_dist[i];
      end
    end
    if (best_cnt > COUNT_MAX) best_cnt = COUNT_MAX;
    res.dist_cm = best_val;
    res.cnt     = CNT_W'(best_cnt);
    return 1'b1;
  endfunction

  // Idle length before a beat: mostly none or short, now and then long.
  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 120);
  endfunction

  // Drive one input beat and hold it until the edge that takes it. Start is
  // only lowered when a gap follows, so a back-to-back beat keeps it high.
  task automatic send_echo(input logic [WIDTH_W-1:0] w, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    in_echo_width_us <= w;
    do @(posedge clk); while (busy);
  endtask

  // Result side: the strobe lasts one cycle and the beat is taken at the edge
  // that ends it. Compare against the oldest expectation.
  always @(posedge clk) begin
    mode_beat_t want;
    if (rst_n && out_valid) begin
      if (mode_q.size() == 0) begin
        $error("result beat with nothing expected: mode_distance_cm %0d mode_count %0d",
               out_mode_distance_cm, out_mode_count);
        err_count++;
      end else begin
        want = mode_q.pop_front();
        if (out_mode_distance_cm !== want.dist_cm) begin
          $error("mode_distance_cm: expected %0d, actual %0d",
                 want.dist_cm, out_mode_distance_cm);
          err_count++;
        end
        if (out_mode_count !== want.cnt) begin
          $error("mode_count: expected %0d, actual %0d", want.cnt, out_mode_count);
          err_count++;
        end
      end
    end
  end

  initial begin
    mode_beat_t         pred;
    logic [WIDTH_W-1:0] w;
    logic [WIDTH_W-1:0] pool [2];
    int                 r;
    bit                 quiet;

    err_count   = 0;
    cycle_count = 0;
    batch_fill  = 0;

    // Hold reset low, then release it on an edge.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: hand-typed results where given, else the predictor.
    for (int k = 0; k < N_ROWS; k++) begin
      send_echo(dir_rows[k].width, pick_gap(1'b0));
      if (log_echo(dir_rows[k].width, pred)) begin
        if (dir_rows[k].typed) begin
          pred.dist_cm = dir_rows[k].dist_cm;
          pred.cnt     = dir_rows[k].cnt;
        end
        mode_q.push_back(pred);
      end
    end

    // Random batches. Each batch draws most widths from two base values with a
    // little jitter so that repeats and ties form; the rest is raw noise,
    // over-range widths and timeouts.
    pool[0] = '0;
    pool[1] = '0;
    for (int k = 0; k < N_RANDOM; k++) begin
      if (batch_fill == 0) begin
        pool[0] = WIDTH_W'($urandom_range(0, WIDTH_LIMIT - 3));
        pool[1] = WIDTH_W'($urandom_range(0, WIDTH_LIMIT - 3));
      end
      r = $urandom_range(0, 9);
      if (r < 2)
        w = WIDTH_W'($urandom_range(0, (1 << WIDTH_W) - 1));
      else if (r == 2)
        w = $urandom_range(0, 1) ? WIDTH_W'($urandom_range(WIDTH_LIMIT + 1, (1 << WIDTH_W) - 1))
                                 : '0;
      else
        w = pool[$urandom_range(0, 1)] + WIDTH_W'($urandom_range(0, 2));

      // Drain completely once mid-run before the next beat.
      if (k == N_RANDOM / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (mode_q.size() != 0) @(posedge clk);
      end

      // Every fourth block of 100 beats runs with no idling.
      quiet = ((k / 100) % 4) == 1;
      send_echo(w, pick_gap(quiet));
      if (log_echo(w, pred)) mode_q.push_back(pred);
    end
    start <= 1'b0;

    // Wait out the last sequencer pass, then give stray beats time to show.
    while (mode_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mode_q.size() != 0) begin
      $error("%0d expected results never arrived", mode_q.size());
      err_count++;
    end

    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== echo_distance_mode_filter.f =====
sv/edmf_pkg.sv
sv/edmf_store.sv
sv/edmf_mode.sv
sv/echo_distance_mode_filter.sv
tb/sv/echo_distance_mode_filter_tb.sv
